// ----- hw/rtl/lrupr_pkg.sv -----
package lrupr_pkg;

  // Default sizes handed to the top level parameters.
  localparam int FRAMES_DEF    = 16;
  localparam int PAGE_BITS_DEF = 16;

  // Frame count register.
  localparam int              CFG_W       = 5;
  localparam logic [CFG_W-1:0] FRAMES_RST = CFG_W'(16);

  // Reference time, stamps and fault total.
  localparam int              TIME_W = 32;
  localparam logic [TIME_W-1:0] SAT  = '1;

  // Width of the frame index field on the result port.
  localparam int FIDX_W = 4;

  // Saturating increment for time and fault counters.
  function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
    logic [TIME_W-1:0] r;
    r = (v == SAT) ? v : v + TIME_W'(1);
    return r;
  endfunction

endpackage

// ----- hw/rtl/lrupr_cell.sv -----
module lrupr_cell #(
  parameter int IW        = 4,
  parameter int PAGE_BITS = 16,
  parameter int IDX       = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_range,
  input  logic                         in_vld,
  input  logic [PAGE_BITS-1:0]         in_page,
  input  logic                         in_hit,
  input  logic [IW-1:0]                in_hit_idx,
  input  logic                         in_emp,
  input  logic [IW-1:0]                in_emp_idx,
  input  logic                         in_min_found,
  input  logic [lrupr_pkg::TIME_W-1:0] in_min_stamp,
  input  logic [IW-1:0]                in_min_idx,
  input  logic [PAGE_BITS-1:0]         in_min_page,
  output logic                         out_vld,
  output logic [PAGE_BITS-1:0]         out_page,
  output logic                         out_hit,
  output logic [IW-1:0]                out_hit_idx,
  output logic                         out_emp,
  output logic [IW-1:0]                out_emp_idx,
  output logic                         out_min_found,
  output logic [lrupr_pkg::TIME_W-1:0] out_min_stamp,
  output logic [IW-1:0]                out_min_idx,
  output logic [PAGE_BITS-1:0]         out_min_page,
  input  logic                         wr_en,
  input  logic                         wr_fill,
  input  logic [IW-1:0]                wr_idx,
  input  logic [PAGE_BITS-1:0]         wr_page,
  input  logic [lrupr_pkg::TIME_W-1:0] wr_stamp
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic                         valid;
  logic [PAGE_BITS-1:0]         page;
  logic [lrupr_pkg::TIME_W-1:0] stamp;
  logic                         take;

  logic                         hit_next;
  logic [IW-1:0]                hit_idx_next;
  logic                         emp_next;
  logic [IW-1:0]                emp_idx_next;
  logic                         min_found_next;
  logic [lrupr_pkg::TIME_W-1:0] min_stamp_next;
  logic [IW-1:0]                min_idx_next;
  logic [PAGE_BITS-1:0]         min_page_next;

  assign take = in_range && in_vld;

  // Fold this frame into the search record that passes through.
  always_comb begin
    hit_next       = in_hit;
    hit_idx_next   = in_hit_idx;
    emp_next       = in_emp;
    emp_idx_next   = in_emp_idx;
    min_found_next = in_min_found;
    min_stamp_next = in_min_stamp;
    min_idx_next   = in_min_idx;
    min_page_next  = in_min_page;
    if (take) begin
      if (!in_hit && valid && (page == in_page)) begin
        hit_next     = 1'b1;
        hit_idx_next = MY_IDX;
      end
      if (!in_emp && !valid) begin
        emp_next     = 1'b1;
        emp_idx_next = MY_IDX;
      end
      if (valid && (!in_min_found || (stamp < in_min_stamp))) begin
        min_found_next = 1'b1;
        min_stamp_next = stamp;
        min_idx_next   = MY_IDX;
        min_page_next  = page;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_page      <= in_page;
    out_hit       <= hit_next;
    out_hit_idx   <= hit_idx_next;
    out_emp       <= emp_next;
    out_emp_idx   <= emp_idx_next;
    out_min_found <= min_found_next;
    out_min_stamp <= min_stamp_next;
    out_min_idx   <= min_idx_next;
    out_min_page  <= min_page_next;
  end

  // Frame contents, written by the commit broadcast.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_en && wr_fill && (wr_idx == MY_IDX)) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == MY_IDX)) begin
      stamp <= wr_stamp;
      if (wr_fill) begin
        page <= wr_page;
      end
    end
  end

endmodule

// ----- hw/rtl/lru_page_replacement_core.sv -----
// Channel     | Ports                                        | Transfer
// ------------+----------------------------------------------+---------------------------
// reference   | start, busy, page_number                     | start high while busy low
// result      | done, hit, frame_index, evicted_valid,       | done high, one cycle only
//             | evicted_page, fault_count                    |
// frame count | cfg_we, cfg_data                             | cfg_we high
//
// A reference holds busy from its transfer until its commit: the lookup walks
// the chain of FRAMES frame cells one cell per cycle, and the result is
// committed at the edge after the last cell.
// The result appears on the ports for one cycle right after the commit edge,
// which is also the first cycle in which start is taken again.
// rst (synchronous, active high) empties all frames, zeroes time and fault
// total and sets the frame count to 16.
// The receiver cannot stall; results are never held back.
module lru_page_replacement_core #(
  parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [PAGE_BITS-1:0]          page_number,
  input  logic                          cfg_we,
  input  logic [lrupr_pkg::CFG_W-1:0]   cfg_data,
  output logic                          done,
  output logic                          hit,
  output logic [lrupr_pkg::FIDX_W-1:0]  frame_index,
  output logic                          evicted_valid,
  output logic [PAGE_BITS-1:0]          evicted_page,
  output logic [lrupr_pkg::TIME_W-1:0]  fault_count
);

  localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam int NW = (CW > lrupr_pkg::CFG_W) ? CW : lrupr_pkg::CFG_W;
  localparam int TW = lrupr_pkg::TIME_W;

  // Search record that travels down the chain, one cell per cycle.
  typedef struct packed {
    logic                 vld;
    logic [PAGE_BITS-1:0] page;
    logic                 hit;
    logic [IW-1:0]        hit_idx;
    logic                 emp;
    logic [IW-1:0]        emp_idx;
    logic                 min_found;
    logic [TW-1:0]        min_stamp;
    logic [IW-1:0]        min_idx;
    logic [PAGE_BITS-1:0] min_page;
  } pkt_t;

  // Commit broadcast to every cell; only the addressed cell takes it.
  typedef struct packed {
    logic                 en;
    logic                 fill;
    logic [IW-1:0]        idx;
    logic [PAGE_BITS-1:0] page;
    logic [TW-1:0]        stamp;
  } wr_t;

  logic [lrupr_pkg::CFG_W-1:0] frames_cfg;
  logic [NW-1:0]               n_eff;
  logic [FRAMES-1:0]           active;
  logic [FRAMES-1:0]           pkt_vld;
  logic [TW-1:0]               ref_time;
  logic [TW-1:0]               fault_total;
  logic [TW-1:0]               fault_total_next;
  logic                        accept;
  pkt_t                        head;
  pkt_t                        chain [FRAMES+1];
  pkt_t                        last;
  wr_t                         wr;
  logic [IW-1:0]               slot;
  logic                        evict;

  assign accept = start && !busy;

  // The frame count register. Zero acts as one, and anything above FRAMES
  // acts as FRAMES.
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_cfg <= lrupr_pkg::FRAMES_RST;
    end else if (cfg_we) begin
      frames_cfg <= cfg_data;
    end
  end

  always_comb begin
    if (frames_cfg == '0) begin
      n_eff = NW'(1);
    end else if (NW'(frames_cfg) > NW'(FRAMES)) begin
      n_eff = NW'(FRAMES);
    end else begin
      n_eff = NW'(frames_cfg);
    end
  end

  // A new reference enters the first cell in the cycle of its transfer.
  always_comb begin
    head      = '0;
    head.vld  = accept;
    head.page = page_number;
  end

  assign chain[0] = head;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    assign active[i]  = (NW'(i) < n_eff);
    assign pkt_vld[i] = chain[i+1].vld;
    lrupr_cell #(
      .IW        (IW),
      .PAGE_BITS (PAGE_BITS),
      .IDX       (i)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .in_range      (active[i]),
      .in_vld        (chain[i].vld),
      .in_page       (chain[i].page),
      .in_hit        (chain[i].hit),
      .in_hit_idx    (chain[i].hit_idx),
      .in_emp        (chain[i].emp),
      .in_emp_idx    (chain[i].emp_idx),
      .in_min_found  (chain[i].min_found),
      .in_min_stamp  (chain[i].min_stamp),
      .in_min_idx    (chain[i].min_idx),
      .in_min_page   (chain[i].min_page),
      .out_vld       (chain[i+1].vld),
      .out_page      (chain[i+1].page),
      .out_hit       (chain[i+1].hit),
      .out_hit_idx   (chain[i+1].hit_idx),
      .out_emp       (chain[i+1].emp),
      .out_emp_idx   (chain[i+1].emp_idx),
      .out_min_found (chain[i+1].min_found),
      .out_min_stamp (chain[i+1].min_stamp),
      .out_min_idx   (chain[i+1].min_idx),
      .out_min_page  (chain[i+1].min_page),
      .wr_en         (wr.en),
      .wr_fill       (wr.fill),
      .wr_idx        (wr.idx),
      .wr_page       (wr.page),
      .wr_stamp      (wr.stamp)
    );
  end

  assign last = chain[FRAMES];

  // Pick the frame: the hit, else the first empty frame, else the oldest.
  always_comb begin
    evict = 1'b0;
    if (last.hit) begin
      slot = last.hit_idx;
    end else if (last.emp) begin
      slot = last.emp_idx;
    end else begin
      slot  = last.min_idx;
      evict = 1'b1;
    end
    wr.en    = last.vld;
    wr.fill  = !last.hit;
    wr.idx   = slot;
    wr.page  = last.page;
    wr.stamp = ref_time;
    fault_total_next = last.hit ? fault_total : lrupr_pkg::sat_inc(fault_total);
  end

  // Time advances when a reference is taken, so its stamp is ready by commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      ref_time    <= '0;
      fault_total <= '0;
      done        <= 1'b0;
    end else begin
      done <= last.vld;
      if (accept) begin
        busy     <= 1'b1;
        ref_time <= lrupr_pkg::sat_inc(ref_time);
      end else if (last.vld) begin
        busy <= 1'b0;
      end
      if (last.vld) begin
        fault_total <= fault_total_next;
      end
    end
  end

  // Result registers; they change only on a commit.
  always_ff @(posedge clk) begin
    if (last.vld) begin
      hit           <= last.hit;
      frame_index   <= lrupr_pkg::FIDX_W'(slot);
      evicted_valid <= evict;
      evicted_page  <= evict ? last.min_page : '0;
      fault_count   <= fault_total_next;
    end
  end

  // At most one search record is in the chain at any time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    $onehot0(pkt_vld))
    else $error("more than one reference in the chain");

  // A result follows a record leaving the last cell.
  a_done_follows_commit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(last.vld))
    else $error("result without a commit");

  // A hit never evicts.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    (done && hit) |-> !evicted_valid)
    else $error("hit reported with an eviction");

  // The fault total never decreases.
  a_fault_monotonic: assert property (@(posedge clk) disable iff (rst)
    last.vld |=> (fault_total >= $past(fault_total)))
    else $error("fault total went down");

  // Busy stays high while a record is in the chain.
  a_busy_during_scan: assert property (@(posedge clk) disable iff (rst)
    (pkt_vld != '0) |-> busy)
    else $error("ready while a reference is in flight");

endmodule
